// ===== design/afl_pkg.sv =====
// Shared types, constants and helper functions of the ASCII frame link.
// Used by afl_front, afl_queue, afl_back and ascii_frame_link_with_keepalive.
// Depends on nothing.
`default_nettype none

package afl_pkg;

	// receive buffer sizing
	localparam int BUFFER_BYTES = 32;
	localparam int WP_W         = $clog2(BUFFER_BYTES + 1);
	localparam int FRAME_LEN    = 17;
	localparam int FIDX_W       = $clog2(FRAME_LEN);

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// result slots of one command
	localparam int PHASE_W = 5;
	localparam logic [PHASE_W-1:0] PH_REPORT   = 5'd0;
	localparam logic [PHASE_W-1:0] PH_TX_FIRST = 5'd1;
	localparam logic [PHASE_W-1:0] PH_TX_LAST  = 5'd17;
	localparam logic [PHASE_W-1:0] PH_STATUS   = 5'd18;

	// ascii characters
	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_SEP   = 8'h3B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	// register reset values and limits
	localparam logic [15:0] IDLE_RST  = 16'd20;
	localparam logic [15:0] RESP_RST  = 16'd1000;
	localparam logic [15:0] POLL_RST  = 16'd500;
	localparam logic [7:0]  RETRY_RST = 8'd3;
	localparam logic [9:0]  MAX_VAL   = 10'd999;
	localparam logic [15:0] SAT16     = 16'hFFFF;
	localparam logic [7:0]  SAT8      = 8'hFF;

	// input item kinds
	localparam logic [1:0] IK_BYTE = 2'd0;
	localparam logic [1:0] IK_TICK = 2'd1;
	localparam logic [1:0] IK_SEND = 2'd2;

	typedef enum logic [1:0] {
		OK_REPORT = 2'd0,
		OK_TX     = 2'd1,
		OK_STATUS = 2'd2
	} out_kind_t;

	typedef enum logic [2:0] {
		R_IDLE_TIMEOUT     = 3'd0,
		R_RESPONSE_TIMEOUT = 3'd1,
		R_POLL_INTERVAL    = 3'd2,
		R_RETRY_LIMIT      = 3'd3,
		R_KEEPALIVE_ENABLE = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		KS_START      = 3'd0,
		KS_WAIT_POLL  = 3'd1,
		KS_SEND       = 3'd2,
		KS_WAIT_REPLY = 3'd3,
		KS_GOT_REPLY  = 3'd4,
		KS_MISSED     = 3'd5,
		KS_OFFLINE    = 3'd6
	} ka_step_t;

	typedef logic [3:0] digit_t;
	// [0] hundreds, [1] tens, [2] ones
	typedef digit_t [2:0] bcd_t;

	// one entry of the command queue: results caused by one input item
	typedef struct packed {
		logic              rep;
		logic              rep_valid;
		logic              rep_off;
		logic              tx;
		logic              tx_off;
		logic              stat;
		logic [3:0][9:0]   rx_vals;
		bcd_t [3:0]        tx_bcd;
	} cmd_t;

	// one result item
	typedef struct packed {
		out_kind_t       kind;
		logic            frame_valid;
		logic [3:0][9:0] vals;
		logic [7:0]      tx_byte;
		logic            offline;
		logic            last;
	} res_t;

	function automatic logic [15:0] sat16_inc(input logic [15:0] v);
		return (v == SAT16) ? v : v + 16'd1;
	endfunction

	function automatic digit_t digit_of(input logic [7:0] c);
		logic [7:0] d;
		d = c - CH_ZERO;
		return (c >= CH_ZERO && c <= CH_NINE) ? d[3:0] : 4'd0;
	endfunction

	function automatic logic [9:0] decode3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		return 10'(digit_of(a)) * 10'd100 + 10'(digit_of(b)) * 10'd10 + 10'(digit_of(c));
	endfunction

	// split a value below 1000 into decimal digits by reciprocal multiplies
	function automatic bcd_t to_bcd(input logic [9:0] v);
		logic [15:0] ph;
		logic [3:0]  h;
		logic [6:0]  r;
		logic [14:0] pt;
		logic [3:0]  t;
		bcd_t        res;
		ph = 16'(v) * 16'd41;
		h = ph[15:12];
		r = 7'(v - 10'(h) * 10'd100);
		pt = 15'(r) * 15'd205;
		t = pt[14:11];
		res[0] = h;
		res[1] = t;
		res[2] = 4'(r - 7'(t) * 7'd10);
		return res;
	endfunction

	// character at a position of the transmitted frame
	function automatic logic [7:0] frame_char(input bcd_t [3:0] vals,
			input logic [FIDX_W-1:0] idx);
		logic [7:0] ch;
		bcd_t       grp;
		grp = vals[idx[3:2]];
		unique case (idx[1:0])
			2'd0: ch = (idx == '0) ? CH_OPEN :
				(idx == FIDX_W'(FRAME_LEN - 1)) ? CH_CLOSE : CH_SEP;
			2'd1: ch = CH_ZERO + 8'(grp[0]);
			2'd2: ch = CH_ZERO + 8'(grp[1]);
			2'd3: ch = CH_ZERO + 8'(grp[2]);
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== design/afl_front.sv =====
// Front end: configuration registers, receive buffer, timers and keepalive
// machine; turns each accepted input transaction into at most one queue command.
// Depends on afl_pkg.
`default_nettype none

module afl_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                acc,
	input  wire logic [1:0]          kind,
	input  wire logic [7:0]          rx_byte,
	input  wire logic [3:0][9:0]     send_vals,
	input  wire logic                wr_en,
	input  wire logic [2:0]          wr_index,
	input  wire logic [15:0]         wr_data,
	output afl_pkg::cmd_t            cmd,
	output logic                     cmd_push
);

	// configuration
	logic [15:0] idle_timeout_q, response_timeout_q, poll_interval_q;
	logic [7:0]  retry_limit_q;
	logic        keepalive_enable_q;

	// link state
	logic [7:0]           rx_store_q [afl_pkg::FRAME_LEN];
	logic [afl_pkg::WP_W-1:0] wp_q, wp_d;
	logic [15:0]          idle_q, idle_d, poll_q, poll_d, reply_q, reply_d;
	logic                 run_q, run_d;
	logic [3:0][9:0]      rxv_q, rxv_d;
	afl_pkg::bcd_t [3:0]  txb_q, txb_d;
	afl_pkg::ka_step_t    step_q, step_d;
	logic [7:0]           miss_q, miss_d;
	logic                 store_we;
	logic                 frame_ok;
	logic [3:0][9:0]      dec_vals;
	logic [9:0]           clamped [4];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q     <= afl_pkg::IDLE_RST;
			response_timeout_q <= afl_pkg::RESP_RST;
			poll_interval_q    <= afl_pkg::POLL_RST;
			retry_limit_q      <= afl_pkg::RETRY_RST;
			keepalive_enable_q <= 1'b1;
		end else if (wr_en) begin
			case (afl_pkg::reg_idx_t'(wr_index))
				afl_pkg::R_IDLE_TIMEOUT:     idle_timeout_q     <= wr_data;
				afl_pkg::R_RESPONSE_TIMEOUT: response_timeout_q <= wr_data;
				afl_pkg::R_POLL_INTERVAL:    poll_interval_q    <= wr_data;
				afl_pkg::R_RETRY_LIMIT:      retry_limit_q      <= wr_data[7:0];
				afl_pkg::R_KEEPALIVE_ENABLE: keepalive_enable_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// delimiter check and value decode of the stored frame
	always_comb begin
		frame_ok = (rx_store_q[0] == afl_pkg::CH_OPEN) && (rx_store_q[4] == afl_pkg::CH_SEP) &&
			(rx_store_q[8] == afl_pkg::CH_SEP) && (rx_store_q[12] == afl_pkg::CH_SEP) &&
			(rx_store_q[16] == afl_pkg::CH_CLOSE);
		for (int i = 0; i < 4; i++) begin
			dec_vals[i] = afl_pkg::decode3(rx_store_q[4*i+1], rx_store_q[4*i+2],
				rx_store_q[4*i+3]);
		end
	end

	// send values clamped to the printable range
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			clamped[i] = (send_vals[i] > afl_pkg::MAX_VAL) ? afl_pkg::MAX_VAL : send_vals[i];
		end
	end

	// next state and queue command
	always_comb begin
		logic [7:0] miss_inc;
		wp_d = wp_q;
		idle_d = idle_q;
		run_d = run_q;
		rxv_d = rxv_q;
		txb_d = txb_q;
		poll_d = poll_q;
		reply_d = reply_q;
		step_d = step_q;
		miss_d = miss_q;
		store_we = 1'b0;
		cmd = '0;
		miss_inc = (miss_q == afl_pkg::SAT8) ? miss_q : miss_q + 8'd1;
		if (acc) begin
			case (kind)
				afl_pkg::IK_BYTE: begin
					if (wp_q < afl_pkg::WP_W'(afl_pkg::BUFFER_BYTES)) begin
						store_we = (wp_q < afl_pkg::WP_W'(afl_pkg::FRAME_LEN));
						wp_d = wp_q + 1'b1;
					end
					idle_d = '0;
					run_d = 1'b1;
				end
				afl_pkg::IK_SEND: begin
					for (int i = 0; i < 4; i++) begin
						txb_d[i] = afl_pkg::to_bcd(clamped[i]);
					end
					cmd.tx = 1'b1;
					cmd.tx_off = (step_q == afl_pkg::KS_OFFLINE);
					poll_d = '0;
				end
				afl_pkg::IK_TICK: begin
					poll_d = afl_pkg::sat16_inc(poll_q);
					reply_d = afl_pkg::sat16_inc(reply_q);
					// frame close comes before the keepalive step
					if (run_q) begin
						idle_d = afl_pkg::sat16_inc(idle_q);
						if (idle_d >= idle_timeout_q) begin
							if (frame_ok) begin
								rxv_d = dec_vals;
							end
							cmd.rep = 1'b1;
							cmd.rep_valid = frame_ok;
							cmd.rep_off = (step_q == afl_pkg::KS_OFFLINE);
							poll_d = '0;
							run_d = 1'b0;
							idle_d = '0;
							wp_d = '0;
						end
					end
					if (keepalive_enable_q) begin
						unique case (step_q)
							afl_pkg::KS_START: begin
								poll_d = '0;
								step_d = afl_pkg::KS_WAIT_POLL;
							end
							afl_pkg::KS_WAIT_POLL: begin
								if (poll_d >= poll_interval_q) step_d = afl_pkg::KS_SEND;
							end
							afl_pkg::KS_SEND: begin
								cmd.tx = 1'b1;
								cmd.tx_off = 1'b0;
								poll_d = '0;
								reply_d = '0;
								step_d = afl_pkg::KS_WAIT_REPLY;
							end
							afl_pkg::KS_WAIT_REPLY: begin
								// a valid frame this tick wins over the timeout
								if (cmd.rep && frame_ok) step_d = afl_pkg::KS_GOT_REPLY;
								else if (reply_d >= response_timeout_q)
									step_d = afl_pkg::KS_MISSED;
							end
							afl_pkg::KS_GOT_REPLY: begin
								miss_d = '0;
								poll_d = '0;
								step_d = afl_pkg::KS_WAIT_POLL;
							end
							afl_pkg::KS_MISSED: begin
								miss_d = miss_inc;
								if (miss_inc >= retry_limit_q) begin
									step_d = afl_pkg::KS_OFFLINE;
									cmd.stat = 1'b1;
								end else begin
									poll_d = '0;
									step_d = afl_pkg::KS_SEND;
								end
							end
							afl_pkg::KS_OFFLINE: ;
							default: step_d = afl_pkg::KS_START;
						endcase
					end
				end
				default: ;
			endcase
		end
		cmd.rx_vals = rxv_d;
		cmd.tx_bcd = txb_d;
		cmd_push = cmd.rep | cmd.tx | cmd.stat;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < afl_pkg::FRAME_LEN; i++) rx_store_q[i] <= '0;
			wp_q    <= '0;
			idle_q  <= '0;
			run_q   <= 1'b0;
			rxv_q   <= '0;
			txb_q   <= '0;
			poll_q  <= '0;
			reply_q <= '0;
			step_q  <= afl_pkg::KS_START;
			miss_q  <= '0;
		end else begin
			if (store_we) rx_store_q[wp_q[afl_pkg::FIDX_W-1:0]] <= rx_byte;
			wp_q    <= wp_d;
			idle_q  <= idle_d;
			run_q   <= run_d;
			rxv_q   <= rxv_d;
			txb_q   <= txb_d;
			poll_q  <= poll_d;
			reply_q <= reply_d;
			step_q  <= step_d;
			miss_q  <= miss_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/afl_queue.sv =====
// Short command queue between the front end and the result sequencer.
// Depends on afl_pkg.
`default_nettype none

module afl_queue (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire afl_pkg::cmd_t din,
	input  wire logic    pop,
	output afl_pkg::cmd_t dout,
	output logic         full,
	output logic         empty
);

	afl_pkg::cmd_t              mem_q [afl_pkg::QDEPTH];
	logic [afl_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [afl_pkg::QPTR_W:0]   count_q;
	logic                       do_push, do_pop;

	assign full    = (count_q == (afl_pkg::QPTR_W+1)'(afl_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/afl_back.sv =====
// Result sequencer: expands each queued command into report, transmit byte
// and link status results, one per popped transaction. Depends on afl_pkg.
`default_nettype none

module afl_back (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire afl_pkg::cmd_t cmd,
	input  wire logic      cmd_empty,
	output logic           cmd_pop,
	output afl_pkg::res_t  res,
	output logic           res_empty,
	input  wire logic      res_pop
);

	afl_pkg::cmd_t              cur_q;
	logic [afl_pkg::PHASE_W-1:0] phase_q, nxt, first;
	logic                       busy_q, has_next, take;
	logic [afl_pkg::FIDX_W-1:0] char_idx;

	assign res_empty = !busy_q;
	assign take      = res_pop && busy_q;
	assign cmd_pop   = !cmd_empty && (!busy_q || (take && !has_next));

	// slot that follows the current one
	always_comb begin
		nxt = afl_pkg::PH_STATUS;
		has_next = 1'b0;
		priority if (phase_q == afl_pkg::PH_REPORT) begin
			if (cur_q.tx) begin
				nxt = afl_pkg::PH_TX_FIRST;
				has_next = 1'b1;
			end else begin
				has_next = cur_q.stat;
			end
		end else if (phase_q == afl_pkg::PH_STATUS) begin
			has_next = 1'b0;
		end else if (phase_q == afl_pkg::PH_TX_LAST) begin
			has_next = cur_q.stat;
		end else begin
			nxt = phase_q + 1'b1;
			has_next = 1'b1;
		end
	end

	// first slot of a new command
	always_comb begin
		priority if (cmd.rep) first = afl_pkg::PH_REPORT;
		else if (cmd.tx) first = afl_pkg::PH_TX_FIRST;
		else first = afl_pkg::PH_STATUS;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= afl_pkg::PH_REPORT;
		end else if (take && has_next) begin
			phase_q <= nxt;
		end else if (cmd_pop) begin
			busy_q  <= 1'b1;
			phase_q <= first;
		end else if (take) begin
			busy_q <= 1'b0;
		end
	end

	// command payload
	always_ff @(posedge clk) begin
		if (cmd_pop) cur_q <= cmd;
	end

	// result fields of the current slot
	assign char_idx = afl_pkg::FIDX_W'(phase_q - afl_pkg::PH_TX_FIRST);
	always_comb begin
		res.vals = cur_q.rx_vals;
		res.last = !has_next;
		res.frame_valid = 1'b0;
		res.tx_byte = '0;
		priority if (phase_q == afl_pkg::PH_REPORT) begin
			res.kind = afl_pkg::OK_REPORT;
			res.frame_valid = cur_q.rep_valid;
			res.offline = cur_q.rep_off;
		end else if (phase_q == afl_pkg::PH_STATUS) begin
			res.kind = afl_pkg::OK_STATUS;
			res.offline = 1'b1;
		end else begin
			res.kind = afl_pkg::OK_TX;
			res.tx_byte = afl_pkg::frame_char(cur_q.tx_bcd, char_idx);
			res.offline = cur_q.tx_off;
		end
	end

endmodule

`default_nettype wire

// ===== design/ascii_frame_link_with_keepalive.sv =====
// Top level of the ASCII frame link endpoint with keepalive.
// Depends on afl_pkg, afl_front, afl_queue and afl_back.
//
// The block takes one input transaction per clock (received byte, tick or send
// request) as long as the four-entry command queue between the front end and
// the result sequencer has room; full rises only when four commands are waiting.
// Results leave one per clock while pop is held: a send request gives 17
// transmit bytes, a tick gives up to 18 results (frame report plus a keepalive
// frame, or report plus link status), a byte gives none. The result sequencer
// sets the output rate, one result per cycle. No clearing pass runs after reset.
`default_nettype none

module ascii_frame_link_with_keepalive (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [9:0]  send_faults,
	input  wire logic [9:0]  send_battery,
	input  wire logic [9:0]  send_force,
	input  wire logic [9:0]  send_speed,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       out_kind,
	output logic             frame_valid,
	output logic [9:0]       faults,
	output logic [9:0]       battery,
	output logic [9:0]       force_res,
	output logic [9:0]       speed,
	output logic [7:0]       tx_byte,
	output logic             link_offline,
	output logic             last,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [15:0] wr_data
);

	afl_pkg::cmd_t   f_cmd, q_cmd;
	afl_pkg::res_t   res;
	logic            f_push, q_full, q_empty, q_pop, acc;
	logic [3:0][9:0] send_vals;

	assign acc       = push && !full;
	assign full      = q_full;
	assign send_vals = {send_speed, send_force, send_battery, send_faults};

	// front end
	afl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.kind      (kind),
		.rx_byte   (rx_byte),
		.send_vals (send_vals),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.cmd       (f_cmd),
		.cmd_push  (f_push)
	);

	// command queue
	afl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    (f_cmd),
		.pop    (q_pop),
		.dout   (q_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	// result sequencer
	afl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_empty (q_empty),
		.cmd_pop   (q_pop),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	// result ports
	assign out_kind     = res.kind;
	assign frame_valid  = res.frame_valid;
	assign faults       = res.vals[0];
	assign battery      = res.vals[1];
	assign force_res    = res.vals[2];
	assign speed        = res.vals[3];
	assign tx_byte      = res.tx_byte;
	assign link_offline = res.offline;
	assign last         = res.last;

`ifndef NO_ASSERTIONS
	// a link status result is always final and reports offline
	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_kind == afl_pkg::OK_STATUS) |-> (last && link_offline))
		else $error("link status result not final or not offline");

	// frame_valid is only set on frame reports
	a_valid_on_report: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_kind != afl_pkg::OK_REPORT) |-> !frame_valid)
		else $error("frame_valid set outside a frame report");

	// a result that is not final is followed at once by the next one
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last) |=> !empty)
		else $error("gap inside the results of one input");

	// transmit bytes are never below the ascii zero character
	a_tx_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_kind == afl_pkg::OK_TX) |-> (tx_byte >= afl_pkg::CH_ZERO))
		else $error("transmit byte out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the ASCII frame link endpoint with keepalive.
// Drives bytes, ticks and send requests through the queue ports and compares every
// result against an in-bench model of the link; depends on afl_pkg and the top level.
`timescale 1ns / 100ps

module testbench;
	import afl_pkg::*;

	localparam logic [1:0] IK_UNUSED   = 2'd3;
	localparam int         STALL_LIMIT = 20000;
	localparam int         SETTLE_CYC  = 40;

	typedef struct packed {
		out_kind_t       kind;
		logic            valid;
		logic [3:0][9:0] vals;
		logic [7:0]      txb;
		logic            offline;
		logic            last;
	} link_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  kind;
	logic [7:0]  rx_byte;
	logic [9:0]  send_faults;
	logic [9:0]  send_battery;
	logic [9:0]  send_force;
	logic [9:0]  send_speed;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  out_kind;
	logic        frame_valid;
	logic [9:0]  faults;
	logic [9:0]  battery;
	logic [9:0]  force_res;
	logic [9:0]  speed;
	logic [7:0]  tx_byte;
	logic        link_offline;
	logic        last;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [15:0] wr_data;

	// results still owed by the link, oldest first
	link_result_t pending_results[$];
	int mismatches = 0;
	int sender_gap_pct = 24;
	int reader_stall_pct = 78;
	int reader_hold = 0;
	int quiet_cycles = 0;

	// register copy
	logic [15:0] idle_limit, reply_limit, poll_limit;
	logic [7:0]  retry_max;
	logic        ka_enabled;

	// link state copy
	logic [7:0]      rx_buf [FRAME_LEN];
	int              rx_pos;
	logic [15:0]     idle_ticks, poll_ticks, reply_ticks;
	logic            idle_armed;
	logic [3:0][9:0] rx_vals, tx_vals;
	ka_step_t        ka_state;
	logic [7:0]      missed;

	ascii_frame_link_with_keepalive u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.rx_byte(rx_byte), .send_faults(send_faults), .send_battery(send_battery),
		.send_force(send_force), .send_speed(send_speed), .empty(empty), .pop(pop),
		.out_kind(out_kind), .frame_valid(frame_valid), .faults(faults),
		.battery(battery), .force_res(force_res), .speed(speed), .tx_byte(tx_byte),
		.link_offline(link_offline), .last(last), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------- link model

	function automatic void reset_link_model();
		idle_limit = IDLE_RST;
		reply_limit = RESP_RST;
		poll_limit = POLL_RST;
		retry_max = RETRY_RST;
		ka_enabled = 1'b1;
		for (int i = 0; i < FRAME_LEN; i++) rx_buf[i] = 8'h00;
		rx_pos = 0;
		idle_ticks = '0;
		poll_ticks = '0;
		reply_ticks = '0;
		idle_armed = 1'b0;
		rx_vals = '0;
		tx_vals = '0;
		ka_state = KS_START;
		missed = '0;
	endfunction

	function automatic int ascii_digit(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) ? int'(c - CH_ZERO) : 0;
	endfunction

	function automatic void owe_result(input out_kind_t k, input logic v, input logic [7:0] t);
		link_result_t r;
		r.kind = k;
		r.valid = v;
		r.vals = rx_vals;
		r.txb = t;
		r.offline = (ka_state == KS_OFFLINE);
		r.last = 1'b0;
		pending_results.push_back(r);
	endfunction

	// the 17 ascii bytes of the stored send values
	function automatic void owe_tx_frame();
		logic [9:0] v;
		owe_result(OK_TX, 1'b0, CH_OPEN);
		for (int i = 0; i < 4; i++) begin
			v = tx_vals[i];
			owe_result(OK_TX, 1'b0, CH_ZERO + 8'(v / 100));
			owe_result(OK_TX, 1'b0, CH_ZERO + 8'((v / 10) % 10));
			owe_result(OK_TX, 1'b0, CH_ZERO + 8'(v % 10));
			owe_result(OK_TX, 1'b0, (i < 3) ? CH_SEP : CH_CLOSE);
		end
		poll_ticks = '0;
	endfunction

	function automatic void predict_link_results(input logic [1:0] k, input logic [7:0] b,
			input logic [3:0][9:0] req);
		int           first;
		logic         got;
		logic         frame_ok;
		link_result_t r;
		first = pending_results.size();
		got = 1'b0;
		case (k)
			IK_BYTE: begin
				if (rx_pos < BUFFER_BYTES) begin
					if (rx_pos < FRAME_LEN) rx_buf[rx_pos] = b;
					rx_pos++;
				end
				idle_ticks = '0;
				idle_armed = 1'b1;
			end
			IK_SEND: begin
				for (int i = 0; i < 4; i++)
					tx_vals[i] = (req[i] > MAX_VAL) ? MAX_VAL : req[i];
				owe_tx_frame();
			end
			IK_TICK: begin
				if (poll_ticks != 16'hFFFF) poll_ticks++;
				if (reply_ticks != 16'hFFFF) reply_ticks++;
				// frame close comes first
				if (idle_armed) begin
					if (idle_ticks != 16'hFFFF) idle_ticks++;
					if (idle_ticks >= idle_limit) begin
						frame_ok = rx_buf[0] == CH_OPEN && rx_buf[4] == CH_SEP &&
							rx_buf[8] == CH_SEP && rx_buf[12] == CH_SEP &&
							rx_buf[16] == CH_CLOSE;
						if (frame_ok)
							for (int i = 0; i < 4; i++)
								rx_vals[i] = 10'(ascii_digit(rx_buf[4 * i + 1]) * 100 +
									ascii_digit(rx_buf[4 * i + 2]) * 10 +
									ascii_digit(rx_buf[4 * i + 3]));
						got = frame_ok;
						owe_result(OK_REPORT, frame_ok, 8'h00);
						poll_ticks = '0;
						idle_armed = 1'b0;
						idle_ticks = '0;
						rx_pos = 0;
					end
				end
				// then one keepalive step
				if (ka_enabled) begin
					case (ka_state)
						KS_START: begin
							poll_ticks = '0;
							ka_state = KS_WAIT_POLL;
						end
						KS_WAIT_POLL: if (poll_ticks >= poll_limit) ka_state = KS_SEND;
						KS_SEND: begin
							owe_tx_frame();
							reply_ticks = '0;
							ka_state = KS_WAIT_REPLY;
						end
						KS_WAIT_REPLY: begin
							if (got) ka_state = KS_GOT_REPLY;
							else if (reply_ticks >= reply_limit) ka_state = KS_MISSED;
						end
						KS_GOT_REPLY: begin
							missed = '0;
							poll_ticks = '0;
							ka_state = KS_WAIT_POLL;
						end
						KS_MISSED: begin
							if (missed != 8'hFF) missed++;
							if (missed >= retry_max) begin
								ka_state = KS_OFFLINE;
								owe_result(OK_STATUS, 1'b0, 8'h00);
							end else begin
								poll_ticks = '0;
								ka_state = KS_SEND;
							end
						end
						KS_OFFLINE: ;
						default: ka_state = KS_START;
					endcase
				end
			end
			default: ;
		endcase
		// flag the final result of this transaction
		if (pending_results.size() > first) begin
			r = pending_results.pop_back();
			r.last = 1'b1;
			pending_results.push_back(r);
		end
	endfunction

	// ---------------------------------------------------------------- drivers

	// one input transaction, with a random gap in front
	task automatic send_item(input logic [1:0] k, input logic [7:0] b, input logic [9:0] f,
			input logic [9:0] bt, input logic [9:0] fr, input logic [9:0] sp);
		while ($urandom_range(99) < sender_gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		rx_byte <= b;
		send_faults <= f;
		send_battery <= bt;
		send_force <= fr;
		send_speed <= sp;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_link_results(k, b, {sp, fr, bt, f});
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(IK_BYTE, b, 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(IK_TICK, 8'($urandom), 10'($urandom), 10'($urandom),
			10'($urandom), 10'($urandom));
	endtask

	task automatic send_request(input logic [9:0] f, input logic [9:0] bt,
			input logic [9:0] fr, input logic [9:0] sp);
		send_item(IK_SEND, 8'($urandom), f, bt, fr, sp);
	endtask

	task automatic send_junk_kind();
		send_item(IK_UNUSED, 8'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
			10'($urandom));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// stop offering and wait until every owed result has left, plus a margin
	task automatic drain_link();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			R_IDLE_TIMEOUT:     idle_limit = d;
			R_RESPONSE_TIMEOUT: reply_limit = d;
			R_POLL_INTERVAL:    poll_limit = d;
			R_RETRY_LIMIT:      retry_max = d[7:0];
			R_KEEPALIVE_ENABLE: ka_enabled = d[0];
			default: ;
		endcase
	endtask

	task automatic set_link_config(input logic [15:0] idle, input logic [15:0] resp,
			input logic [15:0] poll, input logic [7:0] retry, input logic en);
		drain_link();
		write_reg(R_IDLE_TIMEOUT, idle);
		write_reg(R_RESPONSE_TIMEOUT, resp);
		write_reg(R_POLL_INTERVAL, poll);
		write_reg(R_RETRY_LIMIT, 16'(retry));
		write_reg(R_KEEPALIVE_ENABLE, 16'(en));
	endtask

	// ---------------------------------------------------------------- tests

	// frame close: non-digits in an overlong frame, short frame over old bytes
	task automatic test_rx_frames();
		set_link_config(16'd1, 16'hFFFF, 16'hFFFF, 8'd255, 1'b1);
		// runs past the buffer size, only the first 17 bytes are kept
		send_text("{9x9;/0:;100;12 }");
		send_byte(8'h00);
		send_byte(8'hFF);
		repeat (14) send_byte(8'($urandom));
		send_ticks(1);
		// short frame reuses the delimiters left from the long one
		send_text("{555");
		send_ticks(1);
		send_byte(8'h00);
		send_ticks(1);
	endtask

	task automatic test_send_clamp();
		send_request(10'd0, 10'd0, 10'd0, 10'd0);
		send_request(10'd999, 10'd999, 10'd999, 10'd999);
		send_request(10'd1023, 10'd1000, 10'd512, 10'd7);
		send_junk_kind();
	endtask

	// reply lands on the same tick as the reply timeout, then the next keepalive frame goes out
	task automatic test_keepalive_reply();
		set_link_config(16'd2, 16'd2, 16'd1, 8'd255, 1'b1);
		send_ticks(2);
		send_text("{042;100;007;300}");
		send_ticks(2);
		send_ticks(4);
	endtask

	// keepalive off holds its step; a huge idle timeout never closes the frame
	task automatic test_keepalive_disabled();
		set_link_config(16'hFFFF, 16'd1, 16'd1, 8'd255, 1'b0);
		send_ticks(2);
		send_text("{111");
		send_ticks(3);
		send_request(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
	endtask

	task automatic test_zero_timeouts();
		set_link_config(16'd0, 16'd0, 16'd0, 8'd255, 1'b1);
		send_byte(CH_OPEN);
		send_ticks(5);
	endtask

	// long receiver hold-off while send requests keep coming, so full must rise
	task automatic test_input_backpressure();
		drain_link();
		sender_gap_pct = 0;
		reader_hold = 300;
		repeat (6) send_request(10'($urandom), 10'($urandom), 10'($urandom),
			10'($urandom));
	endtask

	task automatic test_random_traffic(input int gap_pct, input int stall_pct,
			input logic [15:0] idle, input logic [15:0] resp, input logic [15:0] poll,
			input logic [7:0] retry);
		logic [7:0] frame_bytes [FRAME_LEN];
		int         sent;
		int         pick;
		int         len;
		int         n;
		set_link_config(idle, resp, poll, retry, 1'b1);
		sender_gap_pct = gap_pct;
		reader_stall_pct = stall_pct;
		sent = 0;
		while (sent < 8) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				// mostly well-formed frames with random digits
				for (int i = 0; i < FRAME_LEN; i++)
					frame_bytes[i] = (i % 4 != 0) ? CH_ZERO + 8'($urandom_range(9)) :
						(i == 0) ? CH_OPEN : (i == FRAME_LEN - 1) ? CH_CLOSE : CH_SEP;
				len = FRAME_LEN;
				if ($urandom_range(9) == 0) len = $urandom_range(1, 40);
				if ($urandom_range(6) == 0)
					frame_bytes[$urandom_range(FRAME_LEN - 1)] = 8'($urandom);
				for (int i = 0; i < len; i++)
					send_byte((i < FRAME_LEN) ? frame_bytes[i] : 8'($urandom));
				n = $urandom_range(1, int'(idle_limit) + 2);
				send_ticks(n);
				sent += len + n;
			end else if (pick < 70) begin
				n = $urandom_range(1, 6);
				send_ticks(n);
				sent += n;
			end else if (pick < 85) begin
				send_request(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
				sent++;
			end else if (pick < 95) begin
				send_byte(8'($urandom));
				sent++;
			end else begin
				send_junk_kind();
			end
		end
	endtask

	// a zero retry limit latches offline on the first miss, which stays put
	task automatic test_offline_latch();
		set_link_config(16'd2, 16'd1, 16'd1, 8'd0, 1'b1);
		send_ticks(6);
		send_text("{808");
		send_ticks(3);
		set_link_config(16'd2, 16'd1, 16'd1, 8'd0, 1'b0);
		send_ticks(2);
		send_request(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
	endtask

	// ---------------------------------------------------------------- checking

	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// result side: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (reader_hold > 0) begin
			reader_hold--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= reader_stall_pct);
		end
	end

	// compare each popped transaction with the oldest owed result
	always @(posedge clk) begin
		link_result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d byte %0d",
					$time, out_kind, tx_byte);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				compare_field("out_kind", 16'(want.kind), 16'(out_kind));
				compare_field("frame_valid", 16'(want.valid), 16'(frame_valid));
				compare_field("faults", 16'(want.vals[0]), 16'(faults));
				compare_field("battery", 16'(want.vals[1]), 16'(battery));
				compare_field("force_res", 16'(want.vals[2]), 16'(force_res));
				compare_field("speed", 16'(want.vals[3]), 16'(speed));
				compare_field("tx_byte", 16'(want.txb), 16'(tx_byte));
				compare_field("link_offline", 16'(want.offline), 16'(link_offline));
				compare_field("last", 16'(want.last), 16'(last));
			end
		end
	end

	// give up when no transaction moves for too long
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		kind = IK_BYTE;
		rx_byte = '0;
		send_faults = '0;
		send_battery = '0;
		send_force = '0;
		send_speed = '0;
		wr_en = 1'b0;
		wr_index = R_IDLE_TIMEOUT;
		wr_data = '0;
		reset_link_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rx_frames();
		test_send_clamp();
		test_keepalive_reply();
		test_keepalive_disabled();
		test_zero_timeouts();
		test_input_backpressure();
		test_random_traffic(24, 78, 16'd3, 16'd6, 16'd3, 8'd255);
		test_random_traffic(78, 24, 16'd2, 16'd12, 16'd5, 8'd200);
		test_random_traffic(0, 0, 16'd1, 16'd3, 16'd2, 8'd255);
		test_offline_latch();

		drain_link();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/afl_pkg.sv
design/afl_front.sv
design/afl_queue.sv
design/afl_back.sv
design/ascii_frame_link_with_keepalive.sv
tb/testbench.sv
